>>> hdl/qds_pkg.sv
`default_nettype none

package qds_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned ACC_W       = 4;
  localparam int unsigned STEP_W      = 3;
  localparam int unsigned RING_DEPTH  = 4;
  localparam int unsigned SPEED_SHIFT = 2;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;

  localparam logic [THR_W-1:0] THR_RESET = 16'd30;

  localparam logic signed [ACC_W-1:0] ACC_DETENT = 4'sd4;

  // register index, taken from paddr above the byte offset
  localparam logic [ADDR_W-3:0] REG_THRESHOLD = 1'b0;

  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_EDGE = 1'b1
  } req_e;

  typedef enum logic {
    DIR_CW  = 1'b0,
    DIR_CCW = 1'b1
  } dir_e;

  // code: bits 1:0 old b,a; bits 3:2 new b,a
  localparam logic signed [STEP_W-1:0] STEP_TABLE [16] = '{
    3'sd0, -3'sd1, 3'sd1, -3'sd2,
    3'sd1, 3'sd0, 3'sd2, -3'sd1,
    -3'sd1, 3'sd2, 3'sd0, 3'sd1,
    -3'sd2, 3'sd1, -3'sd1, 3'sd0
  };

  typedef struct packed {
    req_e              req_type;
    logic              chan_a;
    logic              chan_b;
    logic [TIME_W-1:0] time_ms;
    logic              button_held;
  } item_t;

  typedef struct packed {
    logic emit;
    dir_e direction;
    logic speed_fast;
    logic pressed_during_turn;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/qds_in_if.sv
`default_nettype none

interface qds_in_if;
  import qds_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic              chan_a;
  logic              chan_b;
  logic [TIME_W-1:0] time_ms;
  logic              button_held;

  modport source (
    output valid, req_type, chan_a, chan_b, time_ms, button_held,
    input  ready
  );

  modport sink (
    input  valid, req_type, chan_a, chan_b, time_ms, button_held,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/qds_out_if.sv
`default_nettype none

interface qds_out_if;
  logic valid;
  logic ready;
  logic direction;
  logic speed_fast;
  logic pressed_during_turn;

  modport source (
    output valid, direction, speed_fast, pressed_during_turn,
    input  ready
  );

  modport sink (
    input  valid, direction, speed_fast, pressed_during_turn,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/quadrature_decoder_with_speed_unit.sv
// channel   dir  kind     payload
// req_i     in   req      req_type, chan_a, chan_b, time_ms, button_held
// rsp_o     out  detent   direction, speed_fast, pressed_during_turn
// apb       in   config   fast_threshold_ms at byte address 0
//
// one request per cycle unless rsp_o stalls; a detent passes the input then the result register
// input register, transition table, accumulator and ring update in one pass
// a request that causes no detent is dropped after its pass
// rsp_o stall holds the result register; req_i keeps flowing until both fill
// reset clears levels, accumulator, ring stamps and pointer; threshold to 30
`default_nettype none

module quadrature_decoder_with_speed_unit #(
  parameter int unsigned RingDepth = qds_pkg::RING_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  qds_in_if.sink                     req_i,
  qds_out_if.source                  rsp_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qds_pkg::ADDR_W-1:0] paddr,
  input  logic [qds_pkg::DATA_W-1:0] pwdata,
  output logic [qds_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import qds_pkg::*;

  logic             in_vld_q;
  item_t            item_q, item_d;
  logic             out_vld_q;
  logic             dir_q, fast_q, btn_q;
  logic [THR_W-1:0] thr_q;
  logic             advance, cfg_wr, thr_sel;
  res_t             res;

  assign advance     = in_vld_q & (~out_vld_q | rsp_o.ready);
  assign req_i.ready = ~in_vld_q | advance;

  always_comb begin
    item_d.req_type    = req_e'(req_i.req_type);
    item_d.chan_a      = req_i.chan_a;
    item_d.chan_b      = req_i.chan_b;
    item_d.time_ms     = req_i.time_ms;
    item_d.button_held = req_i.button_held;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q <= item_d;
    end
  end

  qds_track #(
    .RingDepth (RingDepth)
  ) u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .thr_i  (thr_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.emit;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.emit) begin
      dir_q  <= res.direction;
      fast_q <= res.speed_fast;
      btn_q  <= res.pressed_during_turn;
    end
  end

  assign rsp_o.valid               = out_vld_q;
  assign rsp_o.direction           = dir_q;
  assign rsp_o.speed_fast          = fast_q;
  assign rsp_o.pressed_during_turn = btn_q;

  // config port
  assign pready  = 1'b1;
  assign thr_sel = paddr[ADDR_W-1:2] == REG_THRESHOLD;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign prdata  = thr_sel ? DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wr && thr_sel) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  a_thr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_wr && thr_sel) |=> $stable(thr_q))
    else $error("threshold changed without write");

endmodule

`default_nettype wire

>>> hdl/qds_track.sv
`default_nettype none

module qds_track #(
  parameter int unsigned RingDepth = qds_pkg::RING_DEPTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  qds_pkg::item_t             item_i,
  input  logic [qds_pkg::THR_W-1:0]  thr_i,
  output qds_pkg::res_t              res_o
);
  import qds_pkg::*;

  localparam int unsigned PtrW = $clog2(RingDepth);

  logic [1:0]                    prev_q, prev_d;
  logic signed [ACC_W-1:0]       acc_q, acc_d, acc_sum;
  logic [PtrW-1:0]               ptr_q, ptr_d, ptr_nxt;
  logic [TIME_W-1:0]             ring_q [RingDepth];
  logic [TIME_W-1:0]             span;
  logic [3:0]                    code;
  logic signed [STEP_W-1:0]      step;
  logic                          is_edge, up, down;

  always_comb begin
    code    = {item_i.chan_b, item_i.chan_a, prev_q};
    step    = STEP_TABLE[code];
    acc_sum = acc_q + {step[STEP_W-1], step};
    up      = acc_sum >= ACC_DETENT;
    down    = acc_sum <= -ACC_DETENT;
    is_edge = item_i.req_type == REQ_EDGE;

    // slot after the one written now holds the oldest stamp
    ptr_nxt = (ptr_q == PtrW'(RingDepth - 1)) ? '0 : ptr_q + 1'b1;
    span    = item_i.time_ms - ring_q[ptr_nxt];

    res_o.emit                = is_edge & (up | down);
    res_o.direction           = down ? DIR_CCW : DIR_CW;
    res_o.speed_fast          = span[TIME_W-1:SPEED_SHIFT] < (TIME_W - SPEED_SHIFT)'(thr_i);
    res_o.pressed_during_turn = item_i.button_held;

    prev_d = {item_i.chan_b, item_i.chan_a};
    if (!is_edge) begin
      acc_d = acc_q;
    end else if (up) begin
      acc_d = acc_sum - ACC_DETENT;
    end else if (down) begin
      acc_d = acc_sum + ACC_DETENT;
    end else begin
      acc_d = acc_sum;
    end
    ptr_d = res_o.emit ? ptr_nxt : ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
      ptr_q  <= '0;
      for (int i = 0; i < RingDepth; i++) begin
        ring_q[i] <= '0;
      end
    end else if (fire_i) begin
      prev_q <= prev_d;
      acc_q  <= acc_d;
      ptr_q  <= ptr_d;
      if (res_o.emit) begin
        ring_q[ptr_q] <= item_i.time_ms;
      end
    end
  end

  a_acc_after_detent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.emit |=> (acc_q >= -4'sd3) && (acc_q <= 4'sd3))
    else $error("accumulator out of range after detent");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire_i && res_o.emit) |=> $stable(ptr_q))
    else $error("ring pointer moved without detent");

  a_seed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (item_i.req_type == REQ_SEED) |-> !res_o.emit)
    else $error("seed request produced a detent");

endmodule

`default_nettype wire

>>> verif/qds_checker.sv
`timescale 1ns / 100ps

module qds_checker
  import qds_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  qds_in_if                 req_mon,
  qds_out_if                rsp_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                fail_cnt_o,
  output int                pending_o
);

  typedef struct packed {
    dir_e direction;
    logic speed_fast;
    logic pressed_during_turn;
  } detent_t;

  logic [THR_W-1:0]              thr_q;
  logic [1:0]                    prev_lv;
  logic signed [ACC_W-1:0]       acc_q;
  logic [TIME_W-1:0]             stamp_ring [RING_DEPTH];
  logic [$clog2(RING_DEPTH)-1:0] ring_ptr;
  detent_t                       detent_q [$];

  function automatic int transition_step(input logic [3:0] code);
    case (code)
      4'd1, 4'd7, 4'd8, 4'd14: return -1;
      4'd2, 4'd4, 4'd11, 4'd13: return 1;
      4'd3, 4'd12: return -2;
      4'd6, 4'd9: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic logic fast_after_push(input logic [TIME_W-1:0] stamp);
    logic [TIME_W-1:0] span;
    stamp_ring[ring_ptr] = stamp;
    ring_ptr = ring_ptr + 1'b1;
    span = stamp - stamp_ring[ring_ptr];
    return (span >> SPEED_SHIFT) < TIME_W'(thr_q);
  endfunction

  function automatic logic decode_request(input item_t it, output detent_t d);
    logic [3:0] code;
    int         sum;
    logic       hit;
    d = '0;
    hit = 1'b0;
    if (it.req_type == REQ_SEED) begin
      prev_lv = {it.chan_b, it.chan_a};
      return 1'b0;
    end
    code = {it.chan_b, it.chan_a, prev_lv};
    prev_lv = code[3:2];
    sum = int'(acc_q) + transition_step(code);
    if (sum >= int'(ACC_DETENT)) begin
      sum = sum - int'(ACC_DETENT);
      d.direction = DIR_CW;
      hit = 1'b1;
    end else if (sum <= -int'(ACC_DETENT)) begin
      sum = sum + int'(ACC_DETENT);
      d.direction = DIR_CCW;
      hit = 1'b1;
    end
    acc_q = sum[ACC_W-1:0];
    if (hit) begin
      d.speed_fast = fast_after_push(it.time_ms);
      d.pressed_during_turn = it.button_held;
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    detent_t got;
    detent_t want;
    detent_t pred;
    item_t   it;
    if (!rst_ni) begin
      thr_q = THR_RESET;
      prev_lv = '0;
      acc_q = '0;
      ring_ptr = '0;
      foreach (stamp_ring[i]) stamp_ring[i] = '0;
      detent_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.direction = dir_e'(rsp_mon.direction);
        got.speed_fast = rsp_mon.speed_fast;
        got.pressed_during_turn = rsp_mon.pressed_during_turn;
        if (detent_q.size() == 0) begin
          $error("detent with none expected: direction %0d", got.direction);
          fail_cnt_o++;
        end else begin
          want = detent_q.pop_front();
          if (got.direction !== want.direction) begin
            $error("direction: expected %0d, got %0d", want.direction, got.direction);
            fail_cnt_o++;
          end
          if (got.speed_fast !== want.speed_fast) begin
            $error("speed_fast: expected %0d, got %0d", want.speed_fast, got.speed_fast);
            fail_cnt_o++;
          end
          if (got.pressed_during_turn !== want.pressed_during_turn) begin
            $error("pressed_during_turn: expected %0d, got %0d",
                   want.pressed_during_turn, got.pressed_during_turn);
            fail_cnt_o++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        it.req_type = req_e'(req_mon.req_type);
        it.chan_a = req_mon.chan_a;
        it.chan_b = req_mon.chan_b;
        it.time_ms = req_mon.time_ms;
        it.button_held = req_mon.button_held;
        if (decode_request(it, pred)) detent_q.push_back(pred);
      end
      if (psel && penable && pready && paddr[ADDR_W-1:2] == REG_THRESHOLD) begin
        if (pwrite) begin
          thr_q = pwdata[THR_W-1:0];
        end else if (prdata !== DATA_W'(thr_q)) begin
          $error("fast_threshold_ms: expected %0d, got %0d", thr_q, prdata);
          fail_cnt_o++;
        end
      end
      pending_o = detent_q.size();
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import qds_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int PHASE_ITEMS   = 260;
  localparam int NUM_PHASES    = 6;
  localparam int SETTLE_CYCLES = 4;

  localparam logic [ADDR_W-3:0] REG_SPARE = 1'b1;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_cnt;
  int                pending_cnt;
  int                cycle_cnt = 0;

  int                burst_left = 0;
  int                items_sent = 0;
  logic [1:0]        pin_pos = '0;
  logic [TIME_W-1:0] now_ms = '0;

  int                stall_pos = 0;
  int                stall_period = 1;
  int                stall_duty = 1;

  qds_in_if  req_if ();
  qds_out_if rsp_if ();

  quadrature_decoder_with_speed_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  qds_checker u_chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cnt)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // detent sink stall pattern
  always @(negedge clk_i) begin
    if (stall_pos + 1 >= stall_period) begin
      stall_pos = 0;
      if ($urandom_range(0, 3) == 0) begin
        stall_period = $urandom_range(1, 12);
        stall_duty = ($urandom_range(0, 2) == 0) ? stall_period
                                                 : $urandom_range(1, stall_period);
      end
    end else begin
      stall_pos++;
    end
    rsp_if.ready <= (stall_pos < stall_duty);
  end

  function automatic logic [1:0] pins_at(input logic [1:0] pos);
    case (pos)
      2'd0: return 2'b00;
      2'd1: return 2'b10;
      2'd2: return 2'b11;
      default: return 2'b01;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] next_stamp(input logic [1:0] pace);
    logic [TIME_W-1:0] inc;
    case (pace)
      2'd0: inc = $urandom_range(0, 6);
      2'd1: inc = $urandom_range(0, 40);
      2'd2: inc = $urandom_range(20, 600);
      default: inc = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000);
    endcase
    now_ms = now_ms + inc;
    return now_ms;
  endfunction

  task automatic push_req(input req_e kind, input logic [1:0] ab,
                          input logic [TIME_W-1:0] stamp, input logic btn);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.chan_a <= ab[1];
    req_if.chan_b <= ab[0];
    req_if.time_ms <= stamp;
    req_if.button_held <= btn;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [ADDR_W-3:0] idx,
                          input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
  endtask

  task automatic apb_idle();
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic noise_req();
    req_e kind;
    kind = ($urandom_range(0, 3) == 0) ? REQ_SEED : REQ_EDGE;
    pin_pos = 2'($urandom);
    push_req(kind, pins_at(pin_pos), $urandom, 1'($urandom));
  endtask

  // one burst of rotation, sometimes with bounce, skipped or repeated states
  task automatic random_turn();
    int         steps;
    int         dir;
    int         move;
    logic       glitchy;
    logic       btn;
    logic [1:0] pace;
    dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
    steps = $urandom_range(1, 24);
    glitchy = ($urandom_range(0, 4) == 0);
    btn = 1'($urandom);
    pace = 2'($urandom);
    if ($urandom_range(0, 5) == 0) push_req(REQ_SEED, pins_at(pin_pos), next_stamp(pace), btn);
    repeat (steps) begin
      move = dir;
      if (glitchy) begin
        case ($urandom_range(0, 7))
          0: move = -dir;
          1: move = 2 * dir;
          2: move = 0;
          default: move = dir;
        endcase
      end
      if ($urandom_range(0, 7) == 0) btn = ~btn;
      pin_pos = pin_pos + 2'(move);
      push_req(REQ_EDGE, pins_at(pin_pos), next_stamp(pace), btn);
    end
  endtask

  initial begin
    int               phase_end;
    logic [THR_W-1:0] thr;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_SEED;
    req_if.chan_a = 1'b0;
    req_if.chan_b = 1'b0;
    req_if.time_ms = '0;
    req_if.button_held = 1'b0;
    rsp_if.ready = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    apb_xfer(1'b0, REG_THRESHOLD, '0);
    apb_idle();

    push_req(REQ_SEED, 2'b00, 32'd0, 1'b0);
    push_req(REQ_EDGE, 2'b10, 32'd10, 1'b0);
    push_req(REQ_EDGE, 2'b11, 32'd20, 1'b0);
    push_req(REQ_EDGE, 2'b01, 32'd30, 1'b0);
    push_req(REQ_EDGE, 2'b00, 32'd40, 1'b1);
    push_req(REQ_EDGE, 2'b01, 32'hFFFF_FFF0, 1'b0);
    push_req(REQ_EDGE, 2'b11, 32'hFFFF_FFF8, 1'b1);
    push_req(REQ_EDGE, 2'b10, 32'hFFFF_FFFF, 1'b1);
    push_req(REQ_EDGE, 2'b00, 32'h0000_0003, 1'b0);
    push_req(REQ_EDGE, 2'b00, 32'h0000_0010, 1'b0);
    push_req(REQ_EDGE, 2'b11, 32'h0000_0020, 1'b0);
    push_req(REQ_EDGE, 2'b00, 32'h0000_0030, 1'b1);
    push_req(REQ_SEED, 2'b01, 32'h0000_0040, 1'b0);
    push_req(REQ_EDGE, 2'b10, 32'h0000_0050, 1'b0);
    push_req(REQ_EDGE, 2'b01, 32'h0000_0060, 1'b1);
    push_req(REQ_EDGE, 2'b00, 32'h8000_0000, 1'b1);
    push_req(REQ_SEED, 2'b11, 32'h8000_0001, 1'b1);
    push_req(REQ_EDGE, 2'b01, 32'h8000_0002, 1'b0);
    push_req(REQ_EDGE, 2'b00, 32'h8000_0003, 1'b1);
    push_req(REQ_EDGE, 2'b10, 32'hFFFF_FFFF, 1'b1);
    push_req(REQ_EDGE, 2'b10, 32'h5555_AAAA, 1'b0);
    pin_pos = 2'd1;
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: thr = '1;
        1: thr = '0;
        2: thr = 16'($urandom_range(1, 60));
        3: thr = 16'($urandom);
        4: thr = 16'd1;
        default: thr = 16'($urandom_range(8, 200));
      endcase
      apb_xfer(1'b1, REG_THRESHOLD, {16'($urandom), thr});
      if (p == 3) apb_xfer(1'b1, REG_SPARE, $urandom);
      apb_xfer(1'b0, REG_THRESHOLD, '0);
      apb_idle();
      phase_end = items_sent + PHASE_ITEMS;
      push_req(REQ_SEED, pins_at(pin_pos), now_ms, 1'b0);
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 4) == 0) noise_req();
        else random_turn();
      end
      settle();
    end

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
